// ----- design/der_tlv_stream_parser_macros.svh -----
// ----------------------------------------------------------------------------
// DER TLV stream parser: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DER_TLV_STREAM_PARSER_MACROS_SVH
`define DER_TLV_STREAM_PARSER_MACROS_SVH

// Same-cycle implication.
`define DTLV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DTLV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/dtlv_pkg.sv -----
// ----------------------------------------------------------------------------
// DER TLV stream parser package
// Field widths, byte-kind and error codes, and the result beat structure.
// ----------------------------------------------------------------------------
package dtlv_pkg;

    localparam int MAX_LENGTH_BYTES = 7;
    localparam int LEN_CNT_W        = $clog2(MAX_LENGTH_BYTES + 1);
    localparam int LEN_W            = 31;
    localparam int BYTE_W           = 8;
    localparam int KIND_W           = 3;
    localparam int ERR_W            = 3;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = {LEN_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        KIND_TAG        = 3'd0,
        KIND_LENGTH     = 3'd1,
        KIND_VALUE      = 3'd2,
        KIND_DISCARD    = 3'd3,
        KIND_STREAM_END = 3'd4
    } byte_kind_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE       = 3'd0,
        ERR_ZERO_TAG   = 3'd1,
        ERR_LEN_BYTES  = 3'd2,
        ERR_TOO_LARGE  = 3'd3,
        ERR_TRUNCATED  = 3'd4
    } error_code_t;

    // Register index within the configuration space.
    localparam logic [APB_ADDR_W-3:0] REG_MAX_VALUE_LENGTH = '0;

    typedef struct packed {
        byte_kind_t        byte_kind;
        logic [BYTE_W-1:0] element_tag;
        logic [BYTE_W-1:0] value_byte;
        logic [LEN_W-1:0]  value_length;
        logic              element_done;
        error_code_t       error_code;
    } dtlv_result_t;

endpackage

// ----- design/dtlv_stream_ifs.sv -----
// ----------------------------------------------------------------------------
// DER TLV stream parser channel interfaces
// Valid/ready channels for the input byte beats and the result beats.
// ----------------------------------------------------------------------------
interface dtlv_in_if
    import dtlv_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface dtlv_out_if
    import dtlv_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] byte_kind;
    logic [BYTE_W-1:0] element_tag;
    logic [BYTE_W-1:0] value_byte;
    logic [LEN_W-1:0]  value_length;
    logic              element_done;
    logic [ERR_W-1:0]  error_code;

    modport source (output valid, output byte_kind, output element_tag, output value_byte,
                    output value_length, output element_done, output error_code,
                    input ready);
    modport sink   (input valid, input byte_kind, input element_tag, input value_byte,
                    input value_length, input element_done, input error_code,
                    output ready);
endinterface

// ----- design/dtlv_apb_regs.sv -----
// ----------------------------------------------------------------------------
// DER TLV stream parser configuration registers
// APB-style register file holding the largest accepted value length.
// ----------------------------------------------------------------------------
module dtlv_apb_regs
    import dtlv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [LEN_W-1:0]      max_len
);

    logic [LEN_W-1:0]      max_len_reg;
    logic [LEN_W-1:0]      max_len_next;
    logic [APB_ADDR_W-3:0] reg_idx;
    logic                  wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        max_len_next = max_len_reg;
        if (wr_en && (reg_idx == REG_MAX_VALUE_LENGTH))
        begin
            max_len_next = pwdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else
        begin
            max_len_reg <= max_len_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_MAX_VALUE_LENGTH)
        begin
            prdata = {{(APB_DATA_W - LEN_W){1'b0}}, max_len_reg};
        end
    end

    assign max_len = max_len_reg;

endmodule

// ----- design/dtlv_parse_core.sv -----
// ----------------------------------------------------------------------------
// DER TLV stream parser core
// Phase tracking, length decode and byte classification for one beat.
// ----------------------------------------------------------------------------
`include "der_tlv_stream_parser_macros.svh"

module dtlv_parse_core
    import dtlv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              end_of_stream,
    input  logic [LEN_W-1:0]  max_len,
    output dtlv_result_t      result
);

    typedef enum logic [2:0] {
        PH_TAG       = 3'd0,
        PH_LEN_FIRST = 3'd1,
        PH_LEN_LONG  = 3'd2,
        PH_VALUE     = 3'd3,
        PH_DISCARD   = 3'd4
    } phase_t;

    phase_t                 phase_reg,   phase_next;
    logic [BYTE_W-1:0]      tag_reg,     tag_next;
    logic [LEN_W-1:0]       acc_reg,     acc_next;
    logic                   big_reg,     big_next;    // accumulated length beyond 31 bits
    logic [LEN_CNT_W-1:0]   len_left_reg, len_left_next;
    logic [LEN_W-1:0]       val_left_reg, val_left_next;

    logic [BYTE_W-2:0]      n_bytes;
    logic [LEN_W-1:0]       shift_acc;
    logic                   shift_big;
    logic [LEN_CNT_W-1:0]   len_left_dec;
    logic                   fin_en;
    logic [LEN_W-1:0]       fin_len;
    logic                   fin_big;

    assign n_bytes      = data_byte[BYTE_W-2:0];
    assign shift_acc    = {acc_reg[LEN_W-BYTE_W-1:0], data_byte};
    assign shift_big    = big_reg || (acc_reg[LEN_W-1:LEN_W-BYTE_W] != '0);
    assign len_left_dec = len_left_reg - LEN_CNT_W'(1);

    always_comb
    begin
        phase_next    = phase_reg;
        tag_next      = tag_reg;
        acc_next      = acc_reg;
        big_next      = big_reg;
        len_left_next = len_left_reg;
        val_left_next = val_left_reg;
        fin_en        = 1'b0;
        fin_len       = '0;
        fin_big       = 1'b0;

        result.byte_kind    = KIND_DISCARD;
        result.value_byte   = '0;
        result.value_length = '0;
        result.element_done = 1'b0;
        result.error_code   = ERR_NONE;

        if (end_of_stream)
        begin
            result.byte_kind = KIND_STREAM_END;
            if (phase_reg == PH_LEN_FIRST || phase_reg == PH_LEN_LONG ||
                phase_reg == PH_VALUE)
            begin
                result.error_code = ERR_TRUNCATED;
            end
            phase_next    = PH_TAG;
            acc_next      = '0;
            big_next      = 1'b0;
            len_left_next = '0;
            val_left_next = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_TAG:
                begin
                    tag_next = data_byte;
                    acc_next = '0;
                    big_next = 1'b0;
                    if (data_byte == '0)
                    begin
                        result.error_code = ERR_ZERO_TAG;
                        phase_next        = PH_DISCARD;
                    end
                    else
                    begin
                        result.byte_kind = KIND_TAG;
                        phase_next       = PH_LEN_FIRST;
                    end
                end
                PH_LEN_FIRST:
                begin
                    if (data_byte[BYTE_W-1])
                    begin
                        if (n_bytes > (BYTE_W-1)'(MAX_LENGTH_BYTES))
                        begin
                            result.error_code = ERR_LEN_BYTES;
                            phase_next        = PH_DISCARD;
                        end
                        else if (n_bytes == '0)
                        begin
                            fin_en = 1'b1;
                        end
                        else
                        begin
                            result.byte_kind = KIND_LENGTH;
                            acc_next         = '0;
                            big_next         = 1'b0;
                            len_left_next    = n_bytes[LEN_CNT_W-1:0];
                            phase_next       = PH_LEN_LONG;
                        end
                    end
                    else
                    begin
                        fin_en  = 1'b1;
                        fin_len = LEN_W'(n_bytes);
                    end
                end
                PH_LEN_LONG:
                begin
                    acc_next      = shift_acc;
                    big_next      = shift_big;
                    len_left_next = len_left_dec;
                    if (len_left_dec == '0)
                    begin
                        fin_en  = 1'b1;
                        fin_len = shift_acc;
                        fin_big = shift_big;
                    end
                    else
                    begin
                        result.byte_kind = KIND_LENGTH;
                    end
                end
                PH_VALUE:
                begin
                    result.byte_kind    = KIND_VALUE;
                    result.value_byte   = data_byte;
                    result.value_length = acc_reg;
                    val_left_next       = val_left_reg - LEN_W'(1);
                    if (val_left_reg == LEN_W'(1))
                    begin
                        result.element_done = 1'b1;
                        phase_next          = PH_TAG;
                    end
                end
                default:
                begin
                    phase_next = PH_DISCARD;
                end
            endcase

            // The whole length is known: accept it or reject it as too large.
            if (fin_en)
            begin
                len_left_next = '0;
                if (fin_big || (fin_len > max_len))
                begin
                    result.error_code = ERR_TOO_LARGE;
                    acc_next          = '0;
                    big_next          = 1'b0;
                    phase_next        = PH_DISCARD;
                end
                else
                begin
                    result.byte_kind    = KIND_LENGTH;
                    result.value_length = fin_len;
                    acc_next            = fin_len;
                    big_next            = 1'b0;
                    if (fin_len == '0)
                    begin
                        result.element_done = 1'b1;
                        phase_next          = PH_TAG;
                    end
                    else
                    begin
                        val_left_next = fin_len;
                        phase_next    = PH_VALUE;
                    end
                end
            end
        end

        result.element_tag = tag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_TAG;
            tag_reg      <= '0;
            acc_reg      <= '0;
            big_reg      <= 1'b0;
            len_left_reg <= '0;
            val_left_reg <= '0;
        end
        else if (take)
        begin
            phase_reg    <= phase_next;
            tag_reg      <= tag_next;
            acc_reg      <= acc_next;
            big_reg      <= big_next;
            len_left_reg <= len_left_next;
            val_left_reg <= val_left_next;
        end
    end

    `DTLV_ASSERT_NOW(a_value_count_live, clk, rst_n, phase_reg == PH_VALUE,
        val_left_reg != '0, "value phase with no value bytes left")
    `DTLV_ASSERT_NOW(a_len_count_live, clk, rst_n, phase_reg == PH_LEN_LONG,
        len_left_reg != '0, "long length phase with no length bytes left")
    `DTLV_ASSERT_NEXT(a_discard_sticky, clk, rst_n,
        take && phase_reg == PH_DISCARD && !end_of_stream,
        phase_reg == PH_DISCARD, "discard phase left without stream end")
    `DTLV_ASSERT_NOW(a_done_clean, clk, rst_n, result.element_done,
        result.error_code == ERR_NONE && (result.byte_kind == KIND_LENGTH ||
        result.byte_kind == KIND_VALUE), "element completed on a bad beat")

endmodule

// ----- design/dtlv_out_stage.sv -----
// ----------------------------------------------------------------------------
// DER TLV stream parser output stage
// Result register that holds a beat until the receiver takes it.
// ----------------------------------------------------------------------------
module dtlv_out_stage
    import dtlv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  dtlv_result_t      result,
    output logic              can_load,
    dtlv_out_if.source        out_ch
);

    logic         valid_reg, valid_next;
    dtlv_result_t res_reg;

    assign can_load = !valid_reg || out_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= result;
        end
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.byte_kind    = res_reg.byte_kind;
    assign out_ch.element_tag  = res_reg.element_tag;
    assign out_ch.value_byte   = res_reg.value_byte;
    assign out_ch.value_length = res_reg.value_length;
    assign out_ch.element_done = res_reg.element_done;
    assign out_ch.error_code   = res_reg.error_code;

endmodule

// ----- design/der_tlv_stream_parser.sv -----
// ----------------------------------------------------------------------------
// DER TLV stream parser
// Labels each byte of a stream of back-to-back DER TLV elements.
// ----------------------------------------------------------------------------
// Usage: in_ch carries one stream byte per beat, or an end-of-stream mark with
// end_of_stream high (the byte is then ignored). out_ch returns exactly one
// result beat per input beat, in order: the byte kind (tag, length, value,
// discarded or stream end), the current element tag, the passed-through value
// byte, the decoded value length, an element-done flag and an error code.
// The result is registered: a beat accepted at a clock edge is shown on out_ch
// in the cycle after. Throughput is one beat per cycle; the only loop is the
// parse-state update, which settles within the cycle the byte arrives.
// The result register frees itself in the cycle it is taken, so in_ch.ready
// stays high while the receiver keeps up; when the receiver stalls with a
// beat waiting, in_ch.ready drops and the parse state holds until that beat
// is taken.
// Reset leaves the parser in the tag phase with no pending result and the
// maximum value length at 2^31-1. The APB port writes that maximum; write it
// only while no beat is in flight.
// ----------------------------------------------------------------------------
module der_tlv_stream_parser
    import dtlv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    dtlv_in_if.sink               in_ch,
    dtlv_out_if.source            out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [LEN_W-1:0] max_len;
    logic             can_load;
    logic             take;
    dtlv_result_t     result;

    // A beat is taken whenever the result register is free or being emptied.
    assign in_ch.ready = can_load;
    assign take        = in_ch.valid && can_load;

    dtlv_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .max_len (max_len)
    );

    // Classifies the incoming byte and advances the parse state.
    dtlv_parse_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .data_byte     (in_ch.data_byte),
        .end_of_stream (in_ch.end_of_stream),
        .max_len       (max_len),
        .result        (result)
    );

    dtlv_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (take),
        .result   (result),
        .can_load (can_load),
        .out_ch   (out_ch)
    );

endmodule
